FILE: sv/prls_pkg.sv
// shared types, codes and reset values of the parallel rgb led serializer
package prls_pkg;

  // default sizes of the pixel store
  localparam int DEF_LANES    = 8;
  localparam int DEF_MAX_LEDS = 256;

  // one pixel: green 23:16, red 15:8, blue 7:0
  localparam int PIX_W = 24;

  // stream widths, fields packed from bit 0 up, padded to bytes
  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LED_COUNT  = 3'd0,
    CFG_PERIOD     = 3'd1,
    CFG_ZERO_HIGH  = 3'd2,
    CFG_ONE_HIGH   = 3'd3,
    CFG_LATCH      = 3'd4
  } cfg_idx_t;

  localparam logic [8:0] RST_LED_COUNT = 9'd1;
  localparam logic [7:0] RST_PERIOD    = 8'd60;
  localparam logic [7:0] RST_ZERO_HIGH = 8'd18;
  localparam logic [7:0] RST_ONE_HIGH  = 8'd38;
  localparam logic [7:0] RST_LATCH     = 8'd30;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_SET   = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_SUB   = 3'd3,
    CMD_READ  = 3'd4,
    CMD_CLEAR = 3'd5,
    CMD_START = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

  // saturating channel add and subtract
  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hff : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
    return (b >= a) ? 8'h00 : (a - b);
  endfunction

endpackage

FILE: sv/parallel_rgb_led_serializer.sv
// multi-lane rgb led chain driver with a row-wide pixel store
//
// One transaction on in_ carries a command (tick, set, add, subtract, read,
// clear, start) and gives exactly one result transaction on out_ with the
// lane levels after the command, the busy flag, the read colour and the
// start status. In each transaction the accepting edge reads one row of
// the pixel store (all lanes of one led position, so the zero-bit drop
// sees every lane at once), and the compute cycle in ST_EXEC computes,
// writes the row back and loads the output register. A new transaction is
// taken while the last result still waits in the output register; only the
// compute cycle waits for out_tready. After reset and after every clear
// command the store is swept to zero over all MAX_LEDS rows, one row a cycle,
// during which in_tready stays low; configuration writes are taken at any
// time but are meant to be made while no frame is running.
module parallel_rgb_led_serializer #(
  parameter int LANES    = prls_pkg::DEF_LANES,
  parameter int MAX_LEDS = prls_pkg::DEF_MAX_LEDS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: cmd[2:0] lane[5:3] led[13:6] red[21:14] green[29:22] blue[37:30]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [prls_pkg::IN_W-1:0]       in_tdata,
  // out_tdata: pins[7:0] busy_res[8] read_red[16:9] read_green[24:17]
  //            read_blue[32:25] status[33]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [prls_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prls_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int ROW_W  = LANES * prls_pkg::PIX_W;
  localparam int VIS    = (LANES < 8) ? LANES : 8;
  localparam logic [7:0] VIS_MASK = 8'((9'd1 << VIS) - 9'd1);

  // configuration registers
  logic [8:0] led_count_r;
  logic [7:0] period_r;
  logic [7:0] zero_high_r;
  logic [7:0] one_high_r;
  logic [7:0] latch_r;

  // frame timing state
  logic        sending_r, sending_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [13:0] pidx_r, pidx_nxt;
  logic [4:0]  bit_r, bit_nxt;       // period index mod 24
  logic [AW-1:0] ledc_r, ledc_nxt;   // period index div 24
  logic [7:0]  pin_r, pin_nxt;

  // control
  prls_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;

  // captured transaction
  prls_pkg::cmd_t cmd_r;
  logic [2:0]  lane_r;
  logic [7:0]  led_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic        valid_r;
  logic [ROW_W-1:0] rd_row_r;

  // output register
  logic                       out_tvalid_r;
  logic [prls_pkg::OUT_W-1:0] out_tdata_r;

  // pixel store: one row per led position, one 24-bit pixel per lane
  logic [ROW_W-1:0] mem [MAX_LEDS];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [ROW_W-1:0] mem_wd;
  logic [AW-1:0]    mem_ra;

  // incoming fields
  logic [2:0] in_cmd;
  logic [2:0] in_lane;
  logic [7:0] in_led;
  logic       in_fire;
  logic       in_valid_addr;

  assign in_cmd  = in_tdata[2:0];
  assign in_lane = in_tdata[5:3];
  assign in_led  = in_tdata[13:6];

  assign in_tready = (state_r == prls_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_valid_addr = ({2'b00, in_lane} < 5'(LANES)) && (11'(in_led) < 11'(MAX_LEDS));

  // tick reads the row of the current led, everything else the addressed row
  assign mem_ra = (prls_pkg::cmd_t'(in_cmd) == prls_pkg::CMD_TICK) ? ledc_r : AW'(in_led);

  // compute cycle completes once the output register is free
  logic fire;
  assign fire = (state_r == prls_pkg::ST_EXEC) && (!out_tvalid_r || out_tready);

  // frame geometry from configuration
  logic [8:0]  leds_used;
  logic [13:0] data_p;
  logic [13:0] total_p;
  logic [7:0]  period_eff;
  logic [7:0]  one_eff;

  assign leds_used  = (11'(led_count_r) > 11'(MAX_LEDS)) ? 9'(MAX_LEDS) : led_count_r;
  assign data_p     = ({5'b0, leds_used} << 4) + ({5'b0, leds_used} << 3);
  assign total_p    = data_p + {6'b0, latch_r};
  assign period_eff = (period_r == 8'd0) ? 8'd1 : period_r;
  assign one_eff    = (one_high_r >= period_eff) ? (period_eff - 8'd1) : one_high_r;

  // addressed pixel and its modified forms
  logic [LW-1:0]               lane_sel;
  logic [prls_pkg::PIX_W-1:0]  cur_pix;
  logic [prls_pkg::PIX_W-1:0]  new_pix;
  logic [ROW_W-1:0]            new_row;
  logic [7:0]                  ones;
  logic [4:0]                  shift;

  assign lane_sel = LW'(lane_r);
  assign cur_pix  = valid_r ? rd_row_r[lane_sel*prls_pkg::PIX_W +: prls_pkg::PIX_W] : '0;
  assign shift    = 5'd23 - bit_r;

  always_comb begin
    case (cmd_r)
      prls_pkg::CMD_ADD: begin
        new_pix = {prls_pkg::sat_add(cur_pix[23:16], green_r),
                   prls_pkg::sat_add(cur_pix[15:8], red_r),
                   prls_pkg::sat_add(cur_pix[7:0], blue_r)};
      end
      prls_pkg::CMD_SUB: begin
        new_pix = {prls_pkg::sat_sub(cur_pix[23:16], green_r),
                   prls_pkg::sat_sub(cur_pix[15:8], red_r),
                   prls_pkg::sat_sub(cur_pix[7:0], blue_r)};
      end
      default: begin
        new_pix = {green_r, red_r, blue_r};
      end
    endcase
    new_row = rd_row_r;
    new_row[lane_sel*prls_pkg::PIX_W +: prls_pkg::PIX_W] = new_pix;
  end

  // lanes whose current bit is one
  always_comb begin
    logic [prls_pkg::PIX_W-1:0] w;
    ones = 8'h00;
    for (int n = 0; n < VIS; n++) begin
      w = rd_row_r[n*prls_pkg::PIX_W +: prls_pkg::PIX_W];
      ones[n] = w[shift];
    end
  end

  // command execution
  logic       status_bit;
  logic [7:0] rd_red, rd_green, rd_blue;
  logic       store_wr;

  always_comb begin
    logic [8:0] t1;
    logic       done;
    sending_nxt = sending_r;
    tick_nxt    = tick_r;
    pidx_nxt    = pidx_r;
    bit_nxt     = bit_r;
    ledc_nxt    = ledc_r;
    pin_nxt     = pin_r;
    status_bit  = 1'b0;
    rd_red      = 8'h00;
    rd_green    = 8'h00;
    rd_blue     = 8'h00;
    store_wr    = 1'b0;
    t1          = 9'd0;
    done        = 1'b0;
    state_nxt   = prls_pkg::ST_IDLE;
    case (cmd_r)
      prls_pkg::CMD_TICK: begin
        if (sending_r) begin
          if (pidx_r < data_p) begin
            if (tick_r == 8'd0) pin_nxt = VIS_MASK;
            // zero-bit lanes fall first, all lanes later
            if (tick_r == zero_high_r) pin_nxt = pin_nxt & ones;
          end
          if (tick_r == one_eff) begin
            pin_nxt = 8'h00;
            if ((15'(pidx_r) + 15'd1) >= 15'(total_p)) begin
              sending_nxt = 1'b0;
              tick_nxt    = 8'd0;
              pidx_nxt    = 14'd0;
              bit_nxt     = 5'd0;
              ledc_nxt    = '0;
              done        = 1'b1;
            end
          end
          if (!done) begin
            t1 = {1'b0, tick_r} + 9'd1;
            if (t1 >= {1'b0, period_eff}) begin
              tick_nxt = 8'd0;
              pidx_nxt = pidx_r + 14'd1;
              if (bit_r == 5'd23) begin
                bit_nxt  = 5'd0;
                ledc_nxt = ledc_r + AW'(1);
              end else begin
                bit_nxt = bit_r + 5'd1;
              end
            end else begin
              tick_nxt = t1[7:0];
            end
          end
        end
      end
      prls_pkg::CMD_SET, prls_pkg::CMD_ADD, prls_pkg::CMD_SUB: begin
        store_wr = valid_r;
      end
      prls_pkg::CMD_READ: begin
        rd_green = cur_pix[23:16];
        rd_red   = cur_pix[15:8];
        rd_blue  = cur_pix[7:0];
      end
      prls_pkg::CMD_CLEAR: begin
        state_nxt = prls_pkg::ST_CLEAR;
      end
      prls_pkg::CMD_START: begin
        if (sending_r) begin
          status_bit = 1'b1;
        end else begin
          pin_nxt     = 8'h00;
          tick_nxt    = 8'd0;
          pidx_nxt    = 14'd0;
          bit_nxt     = 5'd0;
          ledc_nxt    = '0;
          sending_nxt = (total_p != 14'd0);
        end
      end
      default: begin
      end
    endcase
  end

  // store write port: clearing sweep or write-back of the modified row
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr_r;
    mem_wd = '0;
    if (state_r == prls_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (fire && store_wr) begin
      mem_we = 1'b1;
      mem_wa = AW'(led_r);
      mem_wd = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (in_fire) rd_row_r <= mem[mem_ra];
  end

  // captured transaction, payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= prls_pkg::cmd_t'(in_cmd);
      lane_r  <= in_lane;
      led_r   <= in_led;
      red_r   <= in_tdata[21:14];
      green_r <= in_tdata[29:22];
      blue_r  <= in_tdata[37:30];
      valid_r <= in_valid_addr;
    end
    if (fire) begin
      out_tdata_r <= {6'b0, status_bit, rd_blue, rd_green, rd_red, sending_nxt, pin_nxt};
    end
  end

  // sequencing and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prls_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
      sending_r    <= 1'b0;
      tick_r       <= 8'd0;
      pidx_r       <= 14'd0;
      bit_r        <= 5'd0;
      ledc_r       <= '0;
      pin_r        <= 8'h00;
    end else begin
      case (state_r)
        prls_pkg::ST_IDLE: begin
          if (in_fire) state_r <= prls_pkg::ST_EXEC;
        end
        prls_pkg::ST_EXEC: begin
          if (fire) begin
            state_r    <= state_nxt;
            clr_addr_r <= '0;
          end
        end
        prls_pkg::ST_CLEAR: begin
          if (clr_addr_r == AW'(MAX_LEDS - 1)) begin
            state_r <= prls_pkg::ST_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + AW'(1);
          end
        end
        default: begin
          state_r <= prls_pkg::ST_IDLE;
        end
      endcase
      if (fire) begin
        out_tvalid_r <= 1'b1;
        sending_r    <= sending_nxt;
        tick_r       <= tick_nxt;
        pidx_r       <= pidx_nxt;
        bit_r        <= bit_nxt;
        ledc_r       <= ledc_nxt;
        pin_r        <= pin_nxt;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= prls_pkg::RST_LED_COUNT;
      period_r    <= prls_pkg::RST_PERIOD;
      zero_high_r <= prls_pkg::RST_ZERO_HIGH;
      one_high_r  <= prls_pkg::RST_ONE_HIGH;
      latch_r     <= prls_pkg::RST_LATCH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prls_pkg::CFG_LED_COUNT: led_count_r <= cfg_data;
        prls_pkg::CFG_PERIOD:    period_r    <= cfg_data[7:0];
        prls_pkg::CFG_ZERO_HIGH: zero_high_r <= cfg_data[7:0];
        prls_pkg::CFG_ONE_HIGH:  one_high_r  <= cfg_data[7:0];
        prls_pkg::CFG_LATCH:     latch_r     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // no transaction is taken while the store is being swept
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prls_pkg::ST_CLEAR) |-> !in_tready)
    else $error("input accepted during clearing sweep");

  // lanes stay low whenever no frame is running
  a_pins_low_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (pin_r == 8'h00))
    else $error("lane driven high outside a frame");

  // compute cycle only follows an accepted transaction or a stalled compute
  a_exec_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prls_pkg::ST_EXEC) |->
      ($past(in_tvalid && in_tready) || $past(state_r == prls_pkg::ST_EXEC)))
    else $error("compute cycle without a transaction");

endmodule
